// File: design/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// Shared widths, constants, types and the arctangent table for the lidar
// polar-to-Cartesian point converter.
// ----------------------------------------------------------------------------
package psc_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int RANGE_BITS   = 24;

  localparam int ANGLE_W      = 32;
  localparam int CFG_DATA_W   = 32;
  localparam int FRAC_BITS    = 16;
  localparam int INV_GAIN_W   = 30;
  localparam logic [INV_GAIN_W-1:0] INV_GAIN_Q30 = INV_GAIN_W'(652032874);
  localparam int GAIN_SHIFT   = INV_GAIN_W - FRAC_BITS;

  // product width of the range prescale
  localparam int PROD_W  = RANGE_BITS + INV_GAIN_W;
  // rotation datapath width, with headroom for the CORDIC growth
  localparam int DATA_W  = RANGE_BITS + FRAC_BITS + 3;
  // residual angle width, folded angle plus the sum of the rotation angles
  localparam int ZW      = ANGLE_W + 2;
  localparam int STEP_W  = $clog2(CORDIC_STEPS);
  localparam int ATAN_IDX_W = 5;
  localparam int COORD_W = RANGE_BITS + 1;
  // rounded coordinate, one bit extra so that negation cannot overflow
  localparam int CW      = DATA_W - FRAC_BITS + 1;

  localparam logic signed [CW-1:0] COORD_MAX = CW'((64'd1 << RANGE_BITS) - 64'd1);
  localparam logic signed [CW-1:0] COORD_MIN = ~COORD_MAX;

  typedef enum logic [1:0] {
    REG_START_ANGLE,
    REG_ANGLE_STEP,
    REG_MIN_RANGE,
    REG_MAX_RANGE
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_ROTATE,
    ST_OUTPUT
  } psc_state_t;

  // atan(2^-i) in units of 2^-32 turn, rounded to nearest
  function automatic logic [ANGLE_W-1:0] atan_turns(input logic [ATAN_IDX_W-1:0] idx);
    logic [ANGLE_W-1:0] val;
    case (idx)
      5'd0:  val = 32'd536870912;
      5'd1:  val = 32'd316933406;
      5'd2:  val = 32'd167458907;
      5'd3:  val = 32'd85004756;
      5'd4:  val = 32'd42667331;
      5'd5:  val = 32'd21354465;
      5'd6:  val = 32'd10679838;
      5'd7:  val = 32'd5340245;
      5'd8:  val = 32'd2670163;
      5'd9:  val = 32'd1335087;
      5'd10: val = 32'd667544;
      5'd11: val = 32'd333772;
      5'd12: val = 32'd166886;
      5'd13: val = 32'd83443;
      5'd14: val = 32'd41722;
      5'd15: val = 32'd20861;
      5'd16: val = 32'd10430;
      5'd17: val = 32'd5215;
      5'd18: val = 32'd2608;
      5'd19: val = 32'd1304;
      5'd20: val = 32'd652;
      5'd21: val = 32'd326;
      5'd22: val = 32'd163;
      5'd23: val = 32'd81;
      5'd24: val = 32'd41;
      5'd25: val = 32'd20;
      5'd26: val = 32'd10;
      5'd27: val = 32'd5;
      5'd28: val = 32'd3;
      5'd29: val = 32'd1;
      5'd30: val = 32'd1;
      default: val = 32'd0;
    endcase
    return val;
  endfunction

endpackage

// File: design/psc_channels.sv
// ----------------------------------------------------------------------------
// psc_channels
// Valid/ready channels for range samples in and Cartesian points out.
// ----------------------------------------------------------------------------
interface psc_sample_if;
  import psc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [RANGE_BITS-1:0] range_value;
  logic                  not_finite;
  logic                  scan_end;

  modport source (output valid, range_value, not_finite, scan_end, input ready);
  modport sink   (input valid, range_value, not_finite, scan_end, output ready);
endinterface

interface psc_point_if;
  import psc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic                      point_valid;
  logic                      scan_end_out;

  modport source (output valid, point_x, point_y, point_valid, scan_end_out, input ready);
  modport sink   (input valid, point_x, point_y, point_valid, scan_end_out, output ready);
endinterface

// File: design/psc_cordic.sv
// ----------------------------------------------------------------------------
// psc_cordic
// Iterative CORDIC rotator: one micro-rotation per cycle through a shared
// shift/add unit.
// ----------------------------------------------------------------------------
module psc_cordic (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [psc_pkg::DATA_W-1:0] x0,
  input  logic signed [psc_pkg::ZW-1:0]     z0,
  output logic                             done,
  output logic signed [psc_pkg::DATA_W-1:0] x_out,
  output logic signed [psc_pkg::DATA_W-1:0] y_out
);
  import psc_pkg::*;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  logic signed [DATA_W-1:0] x;
  logic signed [DATA_W-1:0] y;
  logic signed [ZW-1:0]     z;
  logic [STEP_W-1:0]        step;
  logic                     busy;

  logic signed [DATA_W-1:0] dx;
  logic signed [DATA_W-1:0] dy;
  logic signed [ZW-1:0]     da;

  assign dx = y >>> step;
  assign dy = x >>> step;
  assign da = signed'(ZW'(atan_turns(ATAN_IDX_W'(step))));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= x0;
      y <= '0;
      z <= z0;
    end else if (busy) begin
      if (!z[ZW-1]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - da;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + da;
      end
    end
  end

  assign x_out = x;
  assign y_out = y;

endmodule

// File: design/polar_scan_to_cartesian_points.sv
// ----------------------------------------------------------------------------
// polar_scan_to_cartesian_points
// A valid sample is accepted, prescaled, rotated by the CORDIC until done and
// loaded into the output register; an invalid sample goes straight to output load.
// One sample at a time, set by the iterative CORDIC rotator: no new sample is
// accepted until the last one is loaded into the output register, which can stall.
// Reset (rst, synchronous): registers to defaults, angle offset cleared.
// ----------------------------------------------------------------------------
module polar_scan_to_cartesian_points (
  input  logic                             clk,
  input  logic                             rst,
  psc_sample_if.sink                       samples,
  psc_point_if.source                      points,
  input  logic                             wr_en,
  input  psc_pkg::cfg_reg_t                wr_index,
  input  logic [psc_pkg::CFG_DATA_W-1:0]   wr_data
);
  import psc_pkg::*;

  localparam logic [PROD_W-1:0]      ROUND_GAIN = PROD_W'(1) << (GAIN_SHIFT - 1);
  localparam logic signed [DATA_W-1:0] ROUND_HALF = DATA_W'(1) << (FRAC_BITS - 1);

  logic [ANGLE_W-1:0]    start_angle;
  logic [ANGLE_W-1:0]    angle_step;
  logic [RANGE_BITS-1:0] min_range;
  logic [RANGE_BITS-1:0] max_range;
  logic [ANGLE_W-1:0]    angle_offset;

  psc_state_t state;
  psc_state_t state_next;

  logic                  accept;
  logic                  cordic_start;
  logic                  load;
  logic                  sample_ok;
  logic [ANGLE_W-1:0]    angle;
  logic                  fold;
  logic [ANGLE_W-1:0]    folded;

  logic [RANGE_BITS-1:0] range_reg;
  logic                  flip;
  logic                  valid_reg;
  logic                  end_reg;
  logic signed [ZW-1:0]  z0;

  logic [PROD_W-1:0]        prod;
  logic signed [DATA_W-1:0] x0;
  logic                     cordic_done;
  logic signed [DATA_W-1:0] cx;
  logic signed [DATA_W-1:0] cy;

  logic                      out_full;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic                      out_pt_valid;
  logic                      out_end;

  function automatic logic signed [COORD_W-1:0] finish_coord(
    input logic signed [DATA_W-1:0] v,
    input logic                     neg
  );
    logic signed [DATA_W-1:0] rnd;
    logic signed [CW-1:0]     r;
    logic signed [CW-1:0]     s;
    rnd = v + ROUND_HALF;
    r   = {rnd[DATA_W-1], rnd[DATA_W-1:FRAC_BITS]};
    if (neg) begin
      r = -r;
    end
    if (r > COORD_MAX) begin
      s = COORD_MAX;
    end else if (r < COORD_MIN) begin
      s = COORD_MIN;
    end else begin
      s = r;
    end
    return s[COORD_W-1:0];
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      start_angle <= '0;
      angle_step  <= '0;
      min_range   <= '0;
      max_range   <= '1;
    end else if (wr_en) begin
      case (wr_index)
        REG_START_ANGLE: start_angle <= wr_data[ANGLE_W-1:0];
        REG_ANGLE_STEP:  angle_step  <= wr_data[ANGLE_W-1:0];
        REG_MIN_RANGE:   min_range   <= wr_data[RANGE_BITS-1:0];
        REG_MAX_RANGE:   max_range   <= wr_data[RANGE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // angle of this sample, folded into [-1/4, 1/4) turn
  assign angle  = start_angle + angle_offset;
  assign fold   = angle[ANGLE_W-1] ^ angle[ANGLE_W-2];
  assign folded = {angle[ANGLE_W-1] ^ fold, angle[ANGLE_W-2:0]};

  assign sample_ok = !samples.not_finite && (samples.range_value > min_range)
                     && (samples.range_value < max_range);

  assign accept = samples.valid && samples.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_offset <= '0;
    end else if (accept) begin
      angle_offset <= samples.scan_end ? '0 : angle_offset + angle_step;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      range_reg <= samples.range_value;
      flip      <= fold;
      valid_reg <= sample_ok;
      end_reg   <= samples.scan_end;
      z0        <= {{(ZW - ANGLE_W){folded[ANGLE_W-1]}}, folded};
    end
  end

  // range times inverse gain, rounded to FRAC_BITS fraction bits
  assign prod = PROD_W'(range_reg) * PROD_W'(INV_GAIN_Q30) + ROUND_GAIN;
  assign x0   = DATA_W'(prod[PROD_W-1:GAIN_SHIFT]);

  psc_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .x0    (x0),
    .z0    (z0),
    .done  (cordic_done),
    .x_out (cx),
    .y_out (cy)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    samples.ready = 1'b0;
    cordic_start  = 1'b0;
    load          = 1'b0;
    case (state)
      ST_IDLE: begin
        samples.ready = 1'b1;
        if (samples.valid) begin
          state_next = sample_ok ? ST_SCALE : ST_OUTPUT;
        end
      end
      ST_SCALE: begin
        cordic_start = 1'b1;
        state_next   = ST_ROTATE;
      end
      ST_ROTATE: begin
        if (cordic_done) begin
          state_next = ST_OUTPUT;
        end
      end
      ST_OUTPUT: begin
        if (!out_full || points.ready) begin
          load       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (load) begin
      out_full <= 1'b1;
    end else if (points.ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_x        <= valid_reg ? finish_coord(cx, flip) : '0;
      out_y        <= valid_reg ? finish_coord(cy, flip) : '0;
      out_pt_valid <= valid_reg;
      out_end      <= end_reg;
    end
  end

  assign points.valid        = out_full;
  assign points.point_x      = out_x;
  assign points.point_y      = out_y;
  assign points.point_valid  = out_pt_valid;
  assign points.scan_end_out = out_end;

endmodule
